// File: src/assert_macros.svh
// Assertion macros used by the run table top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: src/iprt_pkg.sv
// Types and constants of the interval paint run table.
`default_nettype none
package iprt_pkg;
	localparam int MAX_RUNS = 16384;
	localparam int IDX_W = $clog2(MAX_RUNS);
	localparam int CNT_W = $clog2(MAX_RUNS + 1);
	localparam int COORD_W = 30;
	localparam logic [COORD_W-1:0] LINE_END_RESET = 30'd1000000000;
	localparam logic REG_LINE_END = 1'b0;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_BAD_RANGE = 2'd1,
		ST_FULL = 2'd2,
		ST_NO_WHITE = 2'd3
	} status_t;

	typedef enum logic {
		OP_PAINT = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LAT,
		S_NXT,
		S_L,
		S_M,
		S_R,
		S_END,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [COORD_W-1:0] start;
		logic white;
	} entry_t;

	typedef struct packed {
		logic opcode;
		logic [COORD_W-1:0] range_start;
		logic [COORD_W-1:0] range_end;
		logic paint_white;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [COORD_W-1:0] run_start;
		logic [COORD_W-1:0] run_end;
	} out_item_t;
endpackage
`default_nettype wire

// File: src/iprt_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module iprt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// File: src/interval_paint_run_table.sv
// Top level: run table sequencer over two ping-pong run memories.
// Sequence: a bad-range paint goes straight from idle to the result state; any other
//   item passes LAT, scans each stored run (L, M and R for a paint, L for a query), then END.
// Throughput: one item at a time; the run scan, one memory read per run, sets it.
// Reset: one white run [0, 1000000000); no memory clearing pass is needed.
// Writing line_end resets the table the same way, to one white run ending at line_end.
`default_nettype none
`include "assert_macros.svh"
module interval_paint_run_table (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire iprt_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output iprt_pkg::out_item_t out_data,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int CW = iprt_pkg::COORD_W;
	localparam int NW = iprt_pkg::CNT_W;
	localparam int AW = iprt_pkg::IDX_W;

	// Control state.
	iprt_pkg::state_t state_q, state_d;
	logic [CW-1:0] line_end_q;
	logic [NW-1:0] run_cnt_q;     // runs in the active bank
	logic fresh_q;                // table is the single white run after reset or a line_end write
	logic bank_q;                 // bank holding the live table
	logic [NW-1:0] idx_q;         // run under scan
	logic [NW-1:0] new_cnt_q;     // runs written to the spare bank
	logic mid_done_q;
	logic full_q;
	logic found_q;
	logic out_valid_q;

	// Transaction payload and scan datapath.
	logic op_q;
	logic [CW-1:0] a_q, b_q;
	logic pc_q;
	logic [CW-1:0] cur_s_q, e_q, best_len_q, best_s_q, best_e_q;
	logic cur_c_q, nxt_c_q, prev_c_q;
	iprt_pkg::out_item_t res_q, out_q;

	// Memory side.
	logic [AW-1:0] rd_addr;
	logic wr_en;
	iprt_pkg::entry_t wr_ent;
	iprt_pkg::entry_t rd_raw0, rd_raw1, rd_raw, rd_ent;

	logic in_acc, cfg_wr;
	logic [NW:0] idx_p1, idx_p2;
	logic more1, more2;
	logic seg_do, seg_app, seg_c;
	logic [CW-1:0] seg_st, seg_en, len;
	logic bad_range;

	assign in_acc = in_valid && !in_stall;
	assign in_stall = (state_q != iprt_pkg::S_IDLE);
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == iprt_pkg::REG_LINE_END);
	assign pready = 1'b1;
	assign prdata = (paddr[2] == iprt_pkg::REG_LINE_END) ? {2'b00, line_end_q} : 32'd0;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign idx_p1 = {1'b0, idx_q} + (NW+1)'(1);
	assign idx_p2 = {1'b0, idx_q} + (NW+1)'(2);
	assign more1 = idx_p1 < {1'b0, run_cnt_q};
	assign more2 = idx_p2 < {1'b0, run_cnt_q};
	assign bad_range = (in_data.range_start >= in_data.range_end) ||
		(in_data.range_end > line_end_q);
	assign len = e_q - cur_s_q;

	// Two banks: the live one is read, the spare one takes the rewritten table.
	iprt_ram #(.WIDTH($bits(iprt_pkg::entry_t)), .DEPTH(iprt_pkg::MAX_RUNS)) u_ram0 (
		.clk(clk),
		.we(wr_en && bank_q),
		.addr(bank_q ? new_cnt_q[AW-1:0] : rd_addr),
		.wdata(wr_ent),
		.rdata(rd_raw0)
	);
	iprt_ram #(.WIDTH($bits(iprt_pkg::entry_t)), .DEPTH(iprt_pkg::MAX_RUNS)) u_ram1 (
		.clk(clk),
		.we(wr_en && !bank_q),
		.addr(bank_q ? rd_addr : new_cnt_q[AW-1:0]),
		.wdata(wr_ent),
		.rdata(rd_raw1)
	);
	assign rd_raw = bank_q ? rd_raw1 : rd_raw0;
	// A fresh table is never stored; entry 0 reads as white at zero.
	assign rd_ent = fresh_q ? iprt_pkg::entry_t'{start: '0, white: 1'b1} : rd_raw;

	// Segment offered to the appender in each paint step.
	always_comb begin
		seg_do = 1'b0;
		seg_st = cur_s_q;
		seg_en = e_q;
		seg_c = cur_c_q;
		unique case (state_q)
			iprt_pkg::S_L: begin
				seg_do = (op_q == iprt_pkg::OP_PAINT) && (cur_s_q < a_q);
				seg_en = (e_q < a_q) ? e_q : a_q;
			end
			iprt_pkg::S_M: begin
				seg_do = !mid_done_q && (e_q >= a_q);
				seg_st = a_q;
				seg_en = b_q;
				seg_c = pc_q;
			end
			iprt_pkg::S_R: begin
				seg_do = e_q > b_q;
				seg_st = (cur_s_q > b_q) ? cur_s_q : b_q;
			end
			default: begin
				seg_do = 1'b0;
			end
		endcase
		// Empty segments vanish; one matching the last run's color merges into it.
		seg_app = seg_do && (seg_en > seg_st) &&
			!((new_cnt_q != '0) && (prev_c_q == seg_c));
		wr_en = seg_app && (new_cnt_q != NW'(iprt_pkg::MAX_RUNS));
		wr_ent = '{start: seg_st, white: seg_c};
	end

	// Next state and read requests.
	always_comb begin
		state_d = state_q;
		rd_addr = '0;
		unique case (state_q) inside
			iprt_pkg::S_IDLE: begin
				if (in_acc) begin
					if (in_data.opcode == iprt_pkg::OP_PAINT && bad_range) begin
						state_d = iprt_pkg::S_FIN;
					end else begin
						state_d = iprt_pkg::S_LAT;
					end
				end
			end
			iprt_pkg::S_LAT: begin
				if (more1) begin
					rd_addr = idx_p1[AW-1:0];
					state_d = iprt_pkg::S_NXT;
				end else begin
					state_d = iprt_pkg::S_L;
				end
			end
			iprt_pkg::S_NXT: state_d = iprt_pkg::S_L;
			iprt_pkg::S_M: state_d = iprt_pkg::S_R;
			iprt_pkg::S_L, iprt_pkg::S_R: begin
				if (state_q == iprt_pkg::S_L && op_q == iprt_pkg::OP_PAINT) begin
					state_d = iprt_pkg::S_M;
				end else if (more1) begin
					if (more2) begin
						rd_addr = idx_p2[AW-1:0];
						state_d = iprt_pkg::S_NXT;
					end else begin
						state_d = iprt_pkg::S_L;
					end
				end else begin
					state_d = iprt_pkg::S_END;
				end
			end
			iprt_pkg::S_END: state_d = iprt_pkg::S_FIN;
			iprt_pkg::S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					state_d = iprt_pkg::S_IDLE;
				end
			end
			default: state_d = iprt_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iprt_pkg::S_IDLE;
			line_end_q <= iprt_pkg::LINE_END_RESET;
			run_cnt_q <= NW'(1);
			fresh_q <= 1'b1;
			bank_q <= 1'b0;
			idx_q <= '0;
			new_cnt_q <= '0;
			mid_done_q <= 1'b0;
			full_q <= 1'b0;
			found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// A new result may replace the one leaving in the same cycle.
			if (state_q == iprt_pkg::S_FIN && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				line_end_q <= pwdata[CW-1:0];
				run_cnt_q <= NW'(1);
				fresh_q <= 1'b1;
			end
			if (state_q == iprt_pkg::S_IDLE && in_acc) begin
				idx_q <= '0;
				new_cnt_q <= '0;
				mid_done_q <= 1'b0;
				full_q <= 1'b0;
				found_q <= 1'b0;
			end
			if (state_q == iprt_pkg::S_M && seg_do) begin
				mid_done_q <= 1'b1;
			end
			if (seg_app) begin
				if (new_cnt_q == NW'(iprt_pkg::MAX_RUNS)) begin
					full_q <= 1'b1;
				end else begin
					new_cnt_q <= new_cnt_q + NW'(1);
				end
			end
			if (state_q == iprt_pkg::S_L && op_q == iprt_pkg::OP_QUERY &&
					cur_c_q && e_q > cur_s_q && len > best_len_q) begin
				found_q <= 1'b1;
			end
			if ((state_q == iprt_pkg::S_R ||
					(state_q == iprt_pkg::S_L && op_q == iprt_pkg::OP_QUERY)) && more1) begin
				idx_q <= idx_p1[NW-1:0];
			end
			// Commit the rewritten table by swapping banks.
			if (state_q == iprt_pkg::S_END && op_q == iprt_pkg::OP_PAINT && !full_q) begin
				bank_q <= !bank_q;
				run_cnt_q <= new_cnt_q;
				fresh_q <= 1'b0;
			end
		end
	end

	// Payload and datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == iprt_pkg::S_IDLE && in_acc) begin
			op_q <= in_data.opcode;
			a_q <= in_data.range_start;
			b_q <= in_data.range_end;
			pc_q <= in_data.paint_white;
			best_len_q <= '0;
			best_s_q <= '0;
			best_e_q <= '0;
			res_q <= '{status: iprt_pkg::ST_BAD_RANGE, run_start: '0, run_end: '0};
		end
		if (state_q == iprt_pkg::S_LAT) begin
			cur_s_q <= rd_ent.start;
			cur_c_q <= rd_ent.white;
			if (!more1) begin
				e_q <= line_end_q;
			end
		end
		if (state_q == iprt_pkg::S_NXT) begin
			e_q <= rd_ent.start;
			nxt_c_q <= rd_ent.white;
		end
		if (wr_en) begin
			prev_c_q <= seg_c;
		end
		if (state_q == iprt_pkg::S_L && op_q == iprt_pkg::OP_QUERY &&
				cur_c_q && e_q > cur_s_q && len > best_len_q) begin
			best_len_q <= len;
			best_s_q <= cur_s_q;
			best_e_q <= e_q;
		end
		// Step to the next run: its start is this run's end.
		if ((state_q == iprt_pkg::S_R ||
				(state_q == iprt_pkg::S_L && op_q == iprt_pkg::OP_QUERY)) && more1) begin
			cur_s_q <= e_q;
			cur_c_q <= nxt_c_q;
			if (!more2) begin
				e_q <= line_end_q;
			end
		end
		if (state_q == iprt_pkg::S_END) begin
			if (op_q == iprt_pkg::OP_PAINT) begin
				res_q <= '{status: full_q ? iprt_pkg::ST_FULL : iprt_pkg::ST_OK,
					run_start: '0, run_end: '0};
			end else if (found_q) begin
				res_q <= '{status: iprt_pkg::ST_OK, run_start: best_s_q, run_end: best_e_q};
			end else begin
				res_q <= '{status: iprt_pkg::ST_NO_WHITE, run_start: '0, run_end: '0};
			end
		end
		if (state_q == iprt_pkg::S_FIN && (!out_valid_q || !out_stall)) begin
			out_q <= res_q;
		end
	end

	// Checks. The scan index goes stale once a commit shrinks the table.
	`ASSERT_ALWAYS(a_cnt_range, run_cnt_q != '0 && run_cnt_q <= NW'(iprt_pkg::MAX_RUNS))
	`ASSERT_ALWAYS(a_fresh_single, !fresh_q || run_cnt_q == NW'(1))
	`ASSERT_ALWAYS(a_scan_in_table, state_q == iprt_pkg::S_IDLE || state_q == iprt_pkg::S_FIN || idx_q < run_cnt_q)
	`ASSERT_NEXT(a_full_no_write, full_q && state_q != iprt_pkg::S_IDLE, !$past(wr_en) || !full_q)
endmodule
`default_nettype wire
